@@ hdl/pwm_pkg.sv @@
// Shared types and constants for the window mask unit.
// Used by pwm_layer_logic and ppu_window_mask_unit; depends on nothing.
`default_nettype none

package pwm_pkg;

  localparam int unsigned NumPlainLayers = 5;
  localparam int unsigned NumLayers      = 6;
  localparam int unsigned CfgIdxW        = 3;
  localparam int unsigned CfgDataW       = 16;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_WIN1   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WIN2   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BG1    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_BG2    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BG3    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BG4    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_OBJ    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_COLOR  = 3'd7;

  typedef enum logic [1:0] {
    LOGIC_OR   = 2'd0,
    LOGIC_AND  = 2'd1,
    LOGIC_XOR  = 2'd2,
    LOGIC_XNOR = 2'd3
  } win_logic_e;

  typedef enum logic [1:0] {
    CMODE_ALWAYS  = 2'd0,
    CMODE_INSIDE  = 2'd1,
    CMODE_OUTSIDE = 2'd2,
    CMODE_NEVER   = 2'd3
  } color_mode_e;

  // Low six bits of a layer settings register, MSB first
  typedef struct packed {
    win_logic_e combine;
    logic       inv2;
    logic       en2;
    logic       inv1;
    logic       en1;
  } win_ctrl_t;

endpackage

`default_nettype wire

@@ hdl/pwm_layer_logic.sv @@
// Window combine logic for one layer: two window tests in, one mask bit out.
// Depends on pwm_pkg for the control struct and combine codes.
`default_nettype none

module pwm_layer_logic (
  input  pwm_pkg::win_ctrl_t ctrl_i,
  input  logic               in_win1_i,
  input  logic               in_win2_i,
  output logic               hit_o
);
  import pwm_pkg::*;

  logic w1, w2, combined;

  assign w1 = in_win1_i ^ ctrl_i.inv1;
  assign w2 = in_win2_i ^ ctrl_i.inv2;

  always_comb begin
    case (ctrl_i.combine)
      LOGIC_OR:   combined = w1 | w2;
      LOGIC_AND:  combined = w1 & w2;
      LOGIC_XOR:  combined = w1 ^ w2;
      LOGIC_XNOR: combined = ~(w1 ^ w2);
      default:    combined = 1'b0;
    endcase
  end

  // No window enabled gives the clear value
  always_comb begin
    case ({ctrl_i.en2, ctrl_i.en1})
      2'b01:   hit_o = w1;
      2'b10:   hit_o = w2;
      2'b11:   hit_o = combined;
      default: hit_o = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/ppu_window_mask_unit.sv @@
// Top level of the window mask unit: config registers, two-stage item pipeline.
// Depends on pwm_pkg and pwm_layer_logic.
//
// Each item on the slave stream is one pixel column; one result item with the
// main and sub screen masks for the six layers comes out for it. The block takes
// one item per cycle while the master side does not stall it: the column is registered,
// the window compares and combine gates run combinationally on it, and the masks land in
// the output register. Backpressure on the master side stalls both stages, and
// the input side keeps accepting as long as a stage is free. Configuration
// writes are always ready and take effect in the next cycle; write them only
// while no item is in flight.
`default_nettype none

module ppu_window_mask_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] pixel_x
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [15:0]                   m_axis_tdata,   // [5:0] main_mask, [11:6] sub_mask
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pwm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pwm_pkg::CfgDataW-1:0]  cfg_data_i
);
  import pwm_pkg::*;

  // Configuration registers
  logic [15:0] win1_q, win2_q;
  logic [7:0]  layer_q [NumPlainLayers];
  logic [9:0]  color_q;

  logic cfg_we;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win1_q  <= '0;
      win2_q  <= '0;
      color_q <= '0;
      for (int i = 0; i < NumPlainLayers; i++) begin
        layer_q[i] <= '0;
      end
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_WIN1:  win1_q     <= cfg_data_i;
        REG_WIN2:  win2_q     <= cfg_data_i;
        REG_BG1:   layer_q[0] <= cfg_data_i[7:0];
        REG_BG2:   layer_q[1] <= cfg_data_i[7:0];
        REG_BG3:   layer_q[2] <= cfg_data_i[7:0];
        REG_BG4:   layer_q[3] <= cfg_data_i[7:0];
        REG_OBJ:   layer_q[4] <= cfg_data_i[7:0];
        REG_COLOR: color_q    <= cfg_data_i[9:0];
        default:   ;
      endcase
    end
  end

  // Pipeline handshake
  logic       in_vld_q, out_vld_q;
  logic [7:0] x_q;
  logic       out_free, in_free;

  assign out_free      = ~out_vld_q | m_axis_tready;
  assign in_free       = ~in_vld_q | out_free;
  assign s_axis_tready = in_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_free) in_vld_q <= s_axis_tvalid;
      if (out_free) out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_free && s_axis_tvalid) x_q <= s_axis_tdata;
  end

  // Window compares, shared by all layers
  logic in_win1, in_win2;
  assign in_win1 = (x_q >= win1_q[7:0]) && (x_q <= win1_q[15:8]);
  assign in_win2 = (x_q >= win2_q[7:0]) && (x_q <= win2_q[15:8]);

  logic [NumLayers-1:0] hit;
  logic [5:0]           main_d, sub_d;
  logic [5:0]           main_q, sub_q;

  for (genvar g = 0; g < NumPlainLayers; g++) begin : g_plain
    pwm_layer_logic u_layer (
      .ctrl_i    (win_ctrl_t'(layer_q[g][5:0])),
      .in_win1_i (in_win1),
      .in_win2_i (in_win2),
      .hit_o     (hit[g])
    );
    assign main_d[g] = hit[g] & layer_q[g][6];
    assign sub_d[g]  = hit[g] & layer_q[g][7];
  end

  pwm_layer_logic u_color (
    .ctrl_i    (win_ctrl_t'(color_q[5:0])),
    .in_win1_i (in_win1),
    .in_win2_i (in_win2),
    .hit_o     (hit[NumLayers-1])
  );

  function automatic logic color_bit(color_mode_e mode, logic win);
    case (mode)
      CMODE_ALWAYS:  return 1'b1;
      CMODE_INSIDE:  return win;
      CMODE_OUTSIDE: return ~win;
      default:       return 1'b0;
    endcase
  endfunction

  assign main_d[NumLayers-1] = color_bit(color_mode_e'(color_q[7:6]), hit[NumLayers-1]);
  assign sub_d[NumLayers-1]  = color_bit(color_mode_e'(color_q[9:8]), hit[NumLayers-1]);

  always_ff @(posedge clk_i) begin
    if (out_free && in_vld_q) begin
      main_q <= main_d;
      sub_q  <= sub_d;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {4'b0000, sub_q, main_q};

  // A stalled column must not be overwritten
  a_hold_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !out_free) |=> (in_vld_q && $stable(x_q)))
    else $error("stage one item lost under stall");

  // A result appears only from an item held in stage one
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> $past(in_vld_q))
    else $error("result without source item");

  // An empty pipeline always takes an item
  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!in_vld_q && !out_vld_q) |-> s_axis_tready)
    else $error("empty pipeline not ready");

endmodule

`default_nettype wire

@@ bench/tb_ppu_window_mask_unit.sv @@
// Testbench for ppu_window_mask_unit: directed and random pixel columns under several
// window configurations, checked against a local mask predictor with random stalls.
// Depends on pwm_pkg and the RTL of ppu_window_mask_unit.
module tb_ppu_window_mask_unit;
  import pwm_pkg::*;

  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned WatchLimit  = 3000;
  localparam int unsigned NumPhases   = 12;
  localparam int unsigned PhaseItems  = 140;

  typedef struct packed {
    logic [5:0] sub_m;
    logic [5:0] main_m;
  } masks_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;   // [7:0] pixel_x
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [15:0]         m_axis_tdata;         // [5:0] main_mask, [11:6] sub_mask
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  logic [15:0] shadow_regs [8];
  logic [15:0] cfg_next    [8];
  masks_t      expected_masks [$];
  int unsigned mismatches = 0;
  bit          idle_en  = 1'b1;
  bit          hold_req = 1'b0;

  ppu_window_mask_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- predictor
  function automatic logic [15:0] reg_width_mask(int idx);
    case (idx)
      REG_WIN1, REG_WIN2: return 16'hFFFF;
      REG_COLOR:          return 16'h03FF;
      default:            return 16'h00FF;
    endcase
  endfunction

  function automatic logic in_span(logic [15:0] bounds, logic [7:0] x);
    return (x >= bounds[7:0]) && (x <= bounds[15:8]);
  endfunction

  function automatic logic layer_bit(logic [5:0] ctrl_bits, logic [7:0] x, logic set_val);
    win_ctrl_t c;
    logic      w1, w2, hit;
    c  = win_ctrl_t'(ctrl_bits);
    w1 = in_span(shadow_regs[REG_WIN1], x) ^ c.inv1;
    w2 = in_span(shadow_regs[REG_WIN2], x) ^ c.inv2;
    if (!c.en1 && !c.en2) return ~set_val;
    if (c.en1 && !c.en2) hit = w1;
    else if (!c.en1 && c.en2) hit = w2;
    else begin
      case (c.combine)
        LOGIC_OR:  hit = w1 | w2;
        LOGIC_AND: hit = w1 & w2;
        LOGIC_XOR: hit = w1 ^ w2;
        default:   hit = ~(w1 ^ w2);
      endcase
    end
    return hit ? set_val : ~set_val;
  endfunction

  function automatic logic color_bit(color_mode_e mode, logic [7:0] x);
    logic [5:0] ctrl_bits;
    ctrl_bits = shadow_regs[REG_COLOR][5:0];
    case (mode)
      CMODE_ALWAYS:  return 1'b1;
      CMODE_INSIDE:  return layer_bit(ctrl_bits, x, 1'b1);
      CMODE_OUTSIDE: return layer_bit(ctrl_bits, x, 1'b0);
      default:       return 1'b0;
    endcase
  endfunction

  function automatic masks_t predict_masks(logic [7:0] x);
    masks_t     m;
    logic [7:0] s;
    logic       b;
    m = '0;
    for (int i = 0; i < NumPlainLayers; i++) begin
      s = shadow_regs[REG_BG1 + i][7:0];
      b = layer_bit(s[5:0], x, 1'b1);
      if (s[6]) m.main_m[i] = b;
      if (s[7]) m.sub_m[i]  = b;
    end
    m.main_m[5] = color_bit(color_mode_e'(shadow_regs[REG_COLOR][7:6]), x);
    m.sub_m[5]  = color_bit(color_mode_e'(shadow_regs[REG_COLOR][9:8]), x);
    return m;
  endfunction

  // ------------------------------------------------------------ drive helpers
  task automatic send_pixel(input logic [7:0] x);
    bit ok;
    while (idle_en && $urandom_range(99) < 27) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= x;
    do begin
      @(negedge clk_i);
      ok = s_axis_tready;
      if (ok) expected_masks.push_back(predict_masks(x));
      @(posedge clk_i);
    end while (!ok);
  endtask

  // Drop valid and wait for every outstanding result item
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_masks.size() != 0) @(posedge clk_i);
  endtask

  task automatic commit_config();
    bit ok;
    wait_idle();
    for (int i = REG_WIN1; i <= REG_COLOR; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgIdxW'(i);
      cfg_data_i  <= cfg_next[i];
      do begin
        @(negedge clk_i);
        ok = cfg_ready_o;
        @(posedge clk_i);
      end while (!ok);
      shadow_regs[i] = cfg_next[i] & reg_width_mask(i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] random_bounds();
    logic [7:0] a, b;
    a = 8'($urandom_range(255));
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: begin
        b = 8'($urandom_range(255, a));
        return {b, a};
      end
      2: return {a, a};
      default: begin
        case ($urandom_range(3))
          0: return 16'h0000;
          1: return 16'hFF00;
          2: return 16'hFFFF;
          default: return 16'h00FF;
        endcase
      end
    endcase
  endfunction

  // Favor columns on and next to the window edges
  function automatic logic [7:0] pick_pixel();
    logic [15:0] w;
    logic [7:0]  e;
    if ($urandom_range(99) >= 35) return 8'($urandom);
    w = $urandom_range(1) ? shadow_regs[REG_WIN2] : shadow_regs[REG_WIN1];
    e = $urandom_range(1) ? w[15:8] : w[7:0];
    case ($urandom_range(2))
      0: return e - 8'd1;
      1: return e;
      default: return e + 8'd1;
    endcase
  endfunction

  // ------------------------------------------------------------------- tests
  task automatic test_reset_state();
    send_pixel(8'd0);
    send_pixel(8'd255);
  endtask

  task automatic test_directed();
    logic [7:0] cols_a [9] = '{8'd0, 8'd9, 8'd10, 8'd15, 8'd20, 8'd21, 8'd30, 8'd31, 8'd255};
    // Overlapping windows, every combine logic, inside and outside color modes
    cfg_next[REG_WIN1]  = 16'h140A;
    cfg_next[REG_WIN2]  = 16'h1E0F;
    cfg_next[REG_BG1]   = 16'h00C1;
    cfg_next[REG_BG2]   = 16'h0045;
    cfg_next[REG_BG3]   = 16'h0097;
    cfg_next[REG_BG4]   = 16'h00E5;
    cfg_next[REG_OBJ]   = 16'h007D;
    cfg_next[REG_COLOR] = 16'h0245;
    commit_config();
    foreach (cols_a[i]) send_pixel(cols_a[i]);
    // Empty window one, full window two, screens off, junk in unused bits, never mode
    cfg_next[REG_WIN1]  = 16'h00FF;
    cfg_next[REG_WIN2]  = 16'hFF00;
    cfg_next[REG_BG1]   = 16'hAB05;
    cfg_next[REG_BG2]   = 16'h00C0;
    cfg_next[REG_BG3]   = 16'h00C4;
    cfg_next[REG_BG4]   = 16'h55C1;
    cfg_next[REG_OBJ]   = 16'hFFFF;
    cfg_next[REG_COLOR] = 16'hFDC0;
    commit_config();
    send_pixel(8'd0);
    send_pixel(8'd128);
    send_pixel(8'd255);
    // Single-column windows, inverted XNOR on color, always and never modes
    cfg_next[REG_WIN1]  = 16'h8080;
    cfg_next[REG_WIN2]  = 16'h7F7F;
    cfg_next[REG_BG1]   = 16'h00FF;
    cfg_next[REG_BG2]   = 16'h00EF;
    cfg_next[REG_BG3]   = 16'h00DF;
    cfg_next[REG_BG4]   = 16'h00CF;
    cfg_next[REG_OBJ]   = 16'h00BA;
    cfg_next[REG_COLOR] = 16'h033F;
    commit_config();
    send_pixel(8'd127);
    send_pixel(8'd128);
    send_pixel(8'd129);
  endtask

  task automatic test_random_columns();
    for (int p = 0; p < NumPhases; p++) begin
      for (int i = REG_WIN1; i <= REG_COLOR; i++) begin
        if (p == 0) cfg_next[i] = 16'h0000;
        else if (p == 1) cfg_next[i] = 16'hFFFF;
        else if (i == REG_WIN1 || i == REG_WIN2) cfg_next[i] = random_bounds();
        else cfg_next[i] = 16'($urandom);
      end
      commit_config();
      idle_en = !(p == 4 || p == 5);
      for (int n = 0; n < PhaseItems; n++) send_pixel(pick_pixel());
    end
    idle_en = 1'b1;
  endtask

  // Hold the receiver off while items keep coming so the pipeline fills up
  task automatic test_backpressure();
    cfg_next[REG_WIN1] = random_bounds();
    cfg_next[REG_WIN2] = random_bounds();
    for (int i = REG_BG1; i <= REG_COLOR; i++) cfg_next[i] = 16'($urandom);
    commit_config();
    hold_req = 1'b1;
    for (int n = 0; n < 40; n++) send_pixel(pick_pixel());
  endtask

  // ------------------------------------------------------------ receiver side
  initial begin : sink_ready
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (idle_en) begin
        m_axis_tready <= ($urandom_range(99) >= 27);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Inputs only move at rising edges, so the falling edge sees settled handshakes
  always @(negedge clk_i) begin : check_results
    masks_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_masks.size() == 0) begin
        $error("result item with nothing expected: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_masks.pop_front();
        if (m_axis_tdata[5:0] !== want.main_m) begin
          $error("main_mask: expected %h, got %h", want.main_m, m_axis_tdata[5:0]);
          mismatches++;
        end
        if (m_axis_tdata[11:6] !== want.sub_m) begin
          $error("sub_mask: expected %h, got %h", want.sub_m, m_axis_tdata[11:6]);
          mismatches++;
        end
      end
    end
  end

  always @(negedge clk_i) begin : watchdog
    int unsigned quiet;
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchLimit) begin
        $display("tb_ppu_window_mask_unit NOT OK");
        $finish;
      end
    end
  end

  initial begin
    for (int i = REG_WIN1; i <= REG_COLOR; i++) shadow_regs[i] = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_directed();
    test_random_columns();
    test_backpressure();
    wait_idle();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_ppu_window_mask_unit OK");
    end else begin
      $display("tb_ppu_window_mask_unit NOT OK");
    end
    $finish;
  end

endmodule
